// ===== rtl/core/bba_pkg.sv =====
// ---------------------------------------------------------------------------
// bba_pkg
// Shared constants for the buddy block allocator: field widths, leaf size,
// command and status codes.
// ---------------------------------------------------------------------------
package bba_pkg;

   // default tree depth: pool holds 2^MAX_LEVEL leaves
   localparam int MAX_LEVEL_DEF = 10;

   // bytes per leaf
   localparam int LEAF_BYTES = 16;

   // port field widths
   localparam int CMD_W  = 2;
   localparam int SIZE_W = 15;
   localparam int ADDR_W = 14;
   localparam int STAT_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE_SIZED = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADSIZE = 2'd2;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

endpackage

// ===== rtl/core/bba_ram.sv =====
// ---------------------------------------------------------------------------
// bba_ram
// Simple dual-port synchronous memory, one write and one read per cycle,
// registered read data. No reset of the contents.
// ---------------------------------------------------------------------------
module bba_ram #(
   parameter int ADDR_BITS = 10,
   parameter int WIDTH     = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bba_size.sv =====
// ---------------------------------------------------------------------------
// bba_size
// Turns a byte size into a tree level: rounds up to whole leaves, then to a
// power-of-two leaf count. Flags size zero and sizes beyond the pool.
// ---------------------------------------------------------------------------
module bba_size
   import bba_pkg::*;
#(
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  logic [SIZE_W-1:0]              size_bytes,
   output logic [$clog2(MAX_LEVEL+1)-1:0] level,
   output logic                           size_bad
);

   localparam int LVW = $clog2(MAX_LEVEL + 1);
   localparam int KW  = $clog2(MAX_LEVEL + 2);
   localparam int SW  = SIZE_W + 13;

   logic [SW-1:0] leaves;
   logic [KW-1:0] k;

   // leaf count, rounded up
   assign leaves = SW'((SW'(size_bytes) + SW'(LEAF_BYTES - 1)) / LEAF_BYTES);

   // ceiling log2 of the leaf count, saturating one past the pool
   always_comb begin
      k = '0;
      for (int i = 0; i <= MAX_LEVEL; i++) begin
         if ((SW'(1) << i) < leaves) begin
            k = KW'(i + 1);
         end
      end
   end

   assign size_bad = (size_bytes == '0) || (k > KW'(MAX_LEVEL));
   assign level    = LVW'(KW'(MAX_LEVEL) - k);

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator. Free lists, list links and per-node bits live in
// synchronous memories; a sequencer reads, modifies and writes them back.
// ---------------------------------------------------------------------------
// Sequence: rejected commands are answered in the cycle after start; allocate
//   searches the free lists, pops a block and splits it level by level; free
//   probes level marks, then per merge level walks the list to unlink the buddy.
// Throughput: one command at a time; busy stays high until the result.
// Reset: synchronous, clears control state, then a clearing pass zeroes all
//   2^MAX_LEVEL entries of the pair and level-mark memories (busy high).
// Results are strobed for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
module buddy_block_allocator
   import bba_pkg::*;
#(
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [SIZE_W-1:0] req_size_bytes,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_alloc_address,
   output logic [STAT_W-1:0] rsp_status
);

   localparam int ML     = MAX_LEVEL;
   localparam int LW     = MAX_LEVEL + 1;
   localparam int LVW    = $clog2(MAX_LEVEL + 1);
   localparam int LEAVES = 1 << MAX_LEVEL;

   localparam logic [LW-1:0] NIL = LW'(LEAVES);

   typedef enum logic [17:0] {
      S_CLEAR    = 18'h00001,
      S_IDLE     = 18'h00002,
      S_START    = 18'h00004,
      S_SEARCH   = 18'h00008,
      S_POP_RD   = 18'h00010,
      S_POP_WB   = 18'h00020,
      S_PUSH1    = 18'h00040,
      S_PUSH2    = 18'h00080,
      S_TOG_RD   = 18'h00100,
      S_TOG_WR   = 18'h00200,
      S_MARK     = 18'h00400,
      S_MS_RD    = 18'h00800,
      S_MS_CHK   = 18'h01000,
      S_UNMARK   = 18'h02000,
      S_REL      = 18'h04000,
      S_MERGE    = 18'h08000,
      S_WALK_RD  = 18'h10000,
      S_WALK_CHK = 18'h20000
   } state_type;

   // block span in leaves at a level
   function automatic logic [LW-1:0] span(input logic [LVW-1:0] l);
      span = LW'(1) << (LVW'(ML) - l);
   endfunction

   // heap index of the node holding leaf b at level l
   function automatic logic [ML-1:0] node_idx(input logic [ML-1:0] b,
                                             input logic [LVW-1:0] l);
      node_idx = ((ML'(1) << l) - ML'(1)) + (b >> (LVW'(ML) - l));
   endfunction

   state_type         state_ff, state_in;
   logic [LVW-1:0]    lv_ff, lv_in;
   logic [LVW-1:0]    tgt_ff, tgt_in;
   logic [LW-1:0]     blk_ff, blk_in;
   logic [LW-1:0]     hold_ff, hold_in;
   logic [LW-1:0]     walk_ff, walk_in;
   logic [LW-1:0]     steps_ff, steps_in;
   logic [ML-1:0]     clr_ff, clr_in;
   logic              is_free_ff, is_free_in;
   logic              pool_ff, pool_in;
   logic [LW-1:0]     head_ff [ML+1];
   logic [LW-1:0]     head_in [ML+1];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   // memory ports
   logic          nx_we, pv_we, pr_we, mk_we;
   logic [ML-1:0] nx_wa, pv_wa, pr_wa, mk_wa;
   logic [ML-1:0] nx_ra, pv_ra, pr_ra, mk_ra;
   logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
   logic          pr_wd, mk_wd, pr_rd, mk_rd;

   // request decode
   logic [LVW-1:0] req_level;
   logic           req_size_bad;
   logic [LW-1:0]  req_blk;
   logic           req_addr_ok;

   // working values
   logic [LW-1:0] cur_span;
   logic [LW-1:0] push_blk;
   logic [LW-1:0] buddy;
   logic [LW-1:0] cur_head;

   bba_size #(.MAX_LEVEL(MAX_LEVEL)) u_size (
      .size_bytes (req_size_bytes),
      .level      (req_level),
      .size_bad   (req_size_bad)
   );

   bba_ram #(.ADDR_BITS(ML), .WIDTH(LW)) u_next (
      .clock (clock), .wr_en (nx_we), .wr_addr (nx_wa), .wr_data (nx_wd),
      .rd_addr (nx_ra), .rd_data (nx_rd)
   );

   bba_ram #(.ADDR_BITS(ML), .WIDTH(LW)) u_prev (
      .clock (clock), .wr_en (pv_we), .wr_addr (pv_wa), .wr_data (pv_wd),
      .rd_addr (pv_ra), .rd_data (pv_rd)
   );

   bba_ram #(.ADDR_BITS(ML), .WIDTH(1)) u_pair (
      .clock (clock), .wr_en (pr_we), .wr_addr (pr_wa), .wr_data (pr_wd),
      .rd_addr (pr_ra), .rd_data (pr_rd)
   );

   bba_ram #(.ADDR_BITS(ML), .WIDTH(1)) u_mark (
      .clock (clock), .wr_en (mk_we), .wr_addr (mk_wa), .wr_data (mk_wd),
      .rd_addr (mk_ra), .rd_data (mk_rd)
   );

   // address checks for free commands
   assign req_addr_ok = pool_ff
                        && ((req_block_address % LEAF_BYTES) == 0)
                        && (32'(req_block_address / LEAF_BYTES) < 32'(LEAVES));
   assign req_blk     = LW'(req_block_address / LEAF_BYTES);

   assign cur_span = span(lv_ff);
   assign push_blk = is_free_ff ? blk_ff : (blk_ff + cur_span);
   assign buddy    = blk_ff ^ cur_span;
   assign cur_head = head_ff[lv_ff];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      lv_in         = lv_ff;
      tgt_in        = tgt_ff;
      blk_in        = blk_ff;
      hold_in       = hold_ff;
      walk_in       = walk_ff;
      steps_in      = steps_ff;
      clr_in        = clr_ff;
      is_free_in    = is_free_ff;
      pool_in       = pool_ff;
      head_in       = head_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      nx_we = 1'b0; nx_wa = '0; nx_wd = NIL; nx_ra = '0;
      pv_we = 1'b0; pv_wa = '0; pv_wd = NIL; pv_ra = '0;
      pr_we = 1'b0; pr_wa = '0; pr_wd = 1'b0; pr_ra = '0;
      mk_we = 1'b0; mk_wa = '0; mk_wd = 1'b0; mk_ra = '0;

      unique case (state_ff)
         // zero pair and mark bits after reset
         S_CLEAR: begin
            pr_we  = 1'b1;
            pr_wa  = clr_ff;
            mk_we  = 1'b1;
            mk_wa  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         // take a command
         S_IDLE: begin
            if (start) begin
               rsp_addr_in = '0;
               priority if (req_cmd == CMD_ALLOC) begin
                  if (req_size_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BADSIZE;
                  end else begin
                     tgt_in     = req_level;
                     lv_in      = req_level;
                     is_free_in = 1'b0;
                     state_in   = pool_ff ? S_SEARCH : S_START;
                  end
               end else if (req_cmd == CMD_FREE_SIZED) begin
                  if (req_size_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BADSIZE;
                  end else if (!req_addr_ok
                               || ((req_blk & (span(req_level) - 1'b1)) != '0)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_IGNORED;
                  end else begin
                     blk_in     = req_blk;
                     lv_in      = req_level;
                     is_free_in = 1'b1;
                     state_in   = S_UNMARK;
                  end
               end else if (req_cmd == CMD_FREE) begin
                  if (!req_addr_ok) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_IGNORED;
                  end else begin
                     blk_in     = req_blk;
                     lv_in      = LVW'(ML - 1);
                     is_free_in = 1'b1;
                     state_in   = S_MS_RD;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_IGNORED;
               end
            end
         end

         // first allocation puts the whole pool on the top list
         S_START: begin
            nx_we      = 1'b1;
            pv_we      = 1'b1;
            head_in[0] = '0;
            pool_in    = 1'b1;
            state_in   = S_SEARCH;
         end

         // nearest non-empty list at or above the needed level
         S_SEARCH: begin
            if (!cur_head[ML]) begin
               state_in = S_POP_RD;
            end else if (lv_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOMEM;
               state_in      = S_IDLE;
            end else begin
               lv_in = lv_ff - 1'b1;
            end
         end

         // pop head: fetch its successor
         S_POP_RD: begin
            nx_ra = cur_head[ML-1:0];
            if (!is_free_ff) begin
               blk_in = cur_head;
            end
            state_in = S_POP_WB;
         end

         S_POP_WB: begin
            if (!nx_rd[ML]) begin
               pv_we = 1'b1;
               pv_wa = nx_rd[ML-1:0];
            end
            head_in[lv_ff] = nx_rd[ML] ? NIL : nx_rd;
            state_in       = is_free_ff ? S_MERGE : S_TOG_RD;
         end

         // push to front of the list at the current level
         S_PUSH1: begin
            nx_we          = 1'b1;
            nx_wa          = push_blk[ML-1:0];
            nx_wd          = cur_head;
            pv_we          = 1'b1;
            pv_wa          = push_blk[ML-1:0];
            hold_in        = cur_head;
            head_in[lv_ff] = push_blk;
            state_in       = S_PUSH2;
         end

         S_PUSH2: begin
            if (!hold_ff[ML]) begin
               pv_we = 1'b1;
               pv_wa = hold_ff[ML-1:0];
               pv_wd = push_blk;
            end
            if (is_free_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               state_in = S_TOG_RD;
            end
         end

         // toggle the pair bit of the block at the current level
         S_TOG_RD: begin
            pr_ra = node_idx(blk_ff[ML-1:0], lv_ff - 1'b1);
            if (lv_ff == '0) begin
               if (lv_ff == tgt_ff) begin
                  state_in = S_MARK;
               end else begin
                  lv_in    = lv_ff + 1'b1;
                  state_in = S_PUSH1;
               end
            end else begin
               state_in = S_TOG_WR;
            end
         end

         S_TOG_WR: begin
            pr_we = 1'b1;
            pr_wa = node_idx(blk_ff[ML-1:0], lv_ff - 1'b1);
            pr_wd = ~pr_rd;
            if (!is_free_ff) begin
               if (lv_ff == tgt_ff) begin
                  state_in = S_MARK;
               end else begin
                  lv_in    = lv_ff + 1'b1;
                  state_in = S_PUSH1;
               end
            end else if (~pr_rd) begin
               state_in = S_PUSH1;
            end else if (cur_head == buddy) begin
               state_in = S_POP_RD;
            end else begin
               walk_in  = cur_head;
               steps_in = '0;
               state_in = S_WALK_RD;
            end
         end

         // mark the level of the allocated block and report it
         S_MARK: begin
            if (tgt_ff < LVW'(ML)) begin
               mk_we = 1'b1;
               mk_wa = node_idx(blk_ff[ML-1:0], tgt_ff);
               mk_wd = 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_addr_in   = ADDR_W'(32'(blk_ff[ML-1:0]) * LEAF_BYTES);
            state_in      = S_IDLE;
         end

         // level search from the deepest aligned level upward
         S_MS_RD: begin
            mk_ra = node_idx(blk_ff[ML-1:0], lv_ff);
            if ((blk_ff & (cur_span - 1'b1)) == '0) begin
               state_in = S_MS_CHK;
            end else begin
               lv_in    = LVW'(ML);
               state_in = S_UNMARK;
            end
         end

         S_MS_CHK: begin
            if (mk_rd) begin
               state_in = S_UNMARK;
            end else if (lv_ff == '0) begin
               lv_in    = LVW'(ML);
               state_in = S_UNMARK;
            end else begin
               lv_in    = lv_ff - 1'b1;
               state_in = S_MS_RD;
            end
         end

         // clear the freed block's mark
         S_UNMARK: begin
            if (lv_ff < LVW'(ML)) begin
               mk_we = 1'b1;
               mk_wa = node_idx(blk_ff[ML-1:0], lv_ff);
            end
            state_in = S_REL;
         end

         // merge loop head
         S_REL: begin
            state_in = (lv_ff == '0) ? S_PUSH1 : S_TOG_RD;
         end

         // step up to the parent block
         S_MERGE: begin
            blk_in   = blk_ff & ~cur_span;
            lv_in    = lv_ff - 1'b1;
            state_in = S_REL;
         end

         // walk the list looking for the buddy
         S_WALK_RD: begin
            nx_ra = walk_ff[ML-1:0];
            pv_ra = walk_ff[ML-1:0];
            if (walk_ff[ML] || (steps_ff == NIL)) begin
               state_in = S_MERGE;
            end else begin
               state_in = S_WALK_CHK;
            end
         end

         S_WALK_CHK: begin
            if (walk_ff == buddy) begin
               if (!pv_rd[ML]) begin
                  nx_we = 1'b1;
                  nx_wa = pv_rd[ML-1:0];
                  nx_wd = nx_rd;
               end
               if (!nx_rd[ML]) begin
                  pv_we = 1'b1;
                  pv_wa = nx_rd[ML-1:0];
                  pv_wd = pv_rd;
               end
               state_in = S_MERGE;
            end else begin
               walk_in  = nx_rd;
               steps_in = steps_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pool_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= ML; i++) begin
            head_ff[i] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      lv_ff         <= lv_in;
      tgt_ff        <= tgt_in;
      blk_ff        <= blk_in;
      hold_ff       <= hold_in;
      walk_ff       <= walk_in;
      steps_ff      <= steps_in;
      is_free_ff    <= is_free_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alloc_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== rtl/core/bba_checker.sv =====
// ---------------------------------------------------------------------------
// bba_checker
// Port-level checks for the buddy block allocator, bound to the top level.
// ---------------------------------------------------------------------------
module bba_checker
   import bba_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [ADDR_W-1:0] rsp_alloc_address,
   input logic [STAT_W-1:0] rsp_status
);

   // reset starts the clearing pass with no result
   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy && !rsp_valid)
      else $error("not busy after reset");

   // an accepted item either completes at once or keeps the block busy
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item lost");

   // a result only follows an accept or a busy period
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without an item");

   // failed commands report address zero
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_alloc_address == '0))
      else $error("nonzero address on failure");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_alloc_address (rsp_alloc_address),
   .rsp_status        (rsp_status)
);
